### hw/rtl/abrl_pkg.sv
// Package: shared constants, codes and types of the alert budget rate limiter.
`default_nettype none
package abrl_pkg;
    localparam int DEF_RING_DEPTH = 128;

    localparam int STAMP_W  = 64;
    localparam int OP_W     = 2;
    localparam int LEVEL_W  = 2;
    localparam int MODE_W   = 2;
    localparam int BUDGET_W = 7;
    localparam int S_DATA_W = 72;
    localparam int M_DATA_W = 8;

    localparam logic [BUDGET_W-1:0] BUDGET_RESET = 7'd10;
    localparam logic [21:0]         HOUR_MS      = 22'd3600000;

    localparam logic [OP_W-1:0] OP_DECIDE = 2'd0;
    localparam logic [OP_W-1:0] OP_NOTE   = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

    localparam logic [LEVEL_W-1:0] LVL_ALERT   = 2'd0;
    localparam logic [LEVEL_W-1:0] LVL_AMBIENT = 2'd1;

    localparam logic [MODE_W-1:0] MODE_ALERT   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_AMBIENT = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DIGEST  = 2'd2;

    typedef struct packed {
        logic clr;
        logic en;
    } abrl_scan_ctl_t;
endpackage
`default_nettype wire

### hw/rtl/abrl_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none
module abrl_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 128
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule
`default_nettype wire

### hw/rtl/abrl_recent_unit.sv
// Shared recent-stamp compare and hit counter, one stamp per cycle.
`default_nettype none
module abrl_recent_unit
    import abrl_pkg::*;
#(
    parameter int CNT_W = 8
) (
    input  wire logic                clk,
    input  wire abrl_scan_ctl_t      ctl,
    input  wire logic [STAMP_W-1:0]  now,
    input  wire logic [STAMP_W-1:0]  stamp,
    output logic      [CNT_W-1:0]    count
);
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic [STAMP_W:0]   diff;
    logic               recent;

    // exact signed difference, future stamps are negative and count as recent
    assign diff   = {now[STAMP_W-1], now} - {stamp[STAMP_W-1], stamp};
    assign recent = $signed(diff) < $signed({{(STAMP_W+1-22){1'b0}}, HOUR_MS});

    always_comb begin
        count_next = count_reg;
        if (ctl.clr) begin
            count_next = '0;
        end else if (ctl.en && recent) begin
            count_next = count_reg + 1'b1;
        end
    end

    always_ff @(posedge clk) begin
        count_reg <= count_next;
    end

    assign count = count_reg;
endmodule
`default_nettype wire

### hw/rtl/alert_budget_rate_limiter.sv
// Top level: alert budget rate limiter with stamp ring and scan sequencer.
//
//  channel  dir  tdata                          tuser
//  s_       in   [63:0] now_ms, [65:64] level   [1:0] operation
//  m_       out  [1:0] delivery_mode            -
//  cfg_     in   [6:0] hourly alert budget      -
//
// Note, clear, non-alert decide, or alert decide with zero budget or no stored stamp: handled without a ring scan.
// Alert decide with budget and stored stamps: ring scan, one ring read per cycle.
// s_tready is low during a scan and while an unclaimed result blocks the output.
// Synchronous active-low reset empties the history; ring contents are not cleared.
`default_nettype none
module alert_budget_rate_limiter
    import abrl_pkg::*;
#(
    parameter int RING_DEPTH = DEF_RING_DEPTH
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_wr_en,
    input  wire logic [BUDGET_W-1:0]   cfg_wr_data,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [S_DATA_W-1:0]   s_tdata,   // [63:0] now_ms, [65:64] notify_level
    input  wire logic [OP_W-1:0]       s_tuser,   // [1:0] operation
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic      [M_DATA_W-1:0]   m_tdata    // [1:0] delivery_mode
);
    localparam int AW = $clog2(RING_DEPTH);
    localparam int CW = $clog2(RING_DEPTH + 1);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SCAN = 1'b1;

    logic                 state_reg, state_next;
    logic [AW-1:0]        head_reg, head_next;
    logic [CW-1:0]        fill_reg, fill_next;
    logic [CW-1:0]        issue_reg, issue_next;
    logic                 pend_reg, pend_next;
    logic [BUDGET_W-1:0]  budget_reg, budget_next;
    logic                 mvalid_reg, mvalid_next;
    logic [MODE_W-1:0]    mode_reg, mode_next;
    logic [STAMP_W-1:0]   now_reg, now_next;

    logic                 accept;
    logic [OP_W-1:0]      in_op;
    logic [STAMP_W-1:0]   in_now;
    logic [LEVEL_W-1:0]   in_level;
    logic                 ram_wr_en;
    logic                 ram_rd_en;
    logic [STAMP_W-1:0]   ram_rd_data;
    logic [CW-1:0]        hit_count;
    abrl_scan_ctl_t       scan_ctl;

    assign in_op    = s_tuser;
    assign in_now   = s_tdata[STAMP_W-1:0];
    assign in_level = s_tdata[STAMP_W+LEVEL_W-1:STAMP_W];

    assign s_tready = (state_reg == ST_IDLE) && (!mvalid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;

    assign ram_wr_en = accept && (in_op == OP_NOTE);
    assign ram_rd_en = (state_reg == ST_SCAN) && (issue_reg < fill_reg);

    always_comb begin
        state_next   = state_reg;
        head_next    = head_reg;
        fill_next    = fill_reg;
        issue_next   = issue_reg;
        pend_next    = 1'b0;
        budget_next  = budget_reg;
        mvalid_next  = mvalid_reg;
        mode_next    = mode_reg;
        now_next     = now_reg;
        scan_ctl.clr = 1'b0;
        scan_ctl.en  = pend_reg;

        if (cfg_wr_en) begin
            budget_next = cfg_wr_data;
        end
        if (mvalid_reg && m_tready) begin
            mvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    unique case (in_op)
                        OP_NOTE: begin
                            head_next = (head_reg == AW'(RING_DEPTH - 1)) ? '0
                                                                         : head_reg + 1'b1;
                            if (fill_reg < CW'(RING_DEPTH)) begin
                                fill_next = fill_reg + 1'b1;
                            end
                        end
                        OP_CLEAR: begin
                            head_next = '0;
                            fill_next = '0;
                        end
                        OP_DECIDE: begin
                            if (in_level == LVL_ALERT) begin
                                if (budget_reg != '0 && fill_reg != '0) begin
                                    state_next   = ST_SCAN;
                                    issue_next   = '0;
                                    now_next     = in_now;
                                    scan_ctl.clr = 1'b1;
                                end else begin
                                    mvalid_next = 1'b1;
                                    mode_next   = MODE_ALERT;
                                end
                            end else if (in_level == LVL_AMBIENT) begin
                                mvalid_next = 1'b1;
                                mode_next   = MODE_AMBIENT;
                            end else begin
                                mvalid_next = 1'b1;
                                mode_next   = MODE_DIGEST;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                if (ram_rd_en) begin
                    issue_next = issue_reg + 1'b1;
                    pend_next  = 1'b1;
                end else if (!pend_reg) begin
                    state_next  = ST_IDLE;
                    mvalid_next = 1'b1;
                    mode_next   = (hit_count >= CW'(budget_reg)) ? MODE_AMBIENT : MODE_ALERT;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            head_reg   <= '0;
            fill_reg   <= '0;
            issue_reg  <= '0;
            pend_reg   <= 1'b0;
            budget_reg <= BUDGET_RESET;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            head_reg   <= head_next;
            fill_reg   <= fill_next;
            issue_reg  <= issue_next;
            pend_reg   <= pend_next;
            budget_reg <= budget_next;
            mvalid_reg <= mvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        mode_reg <= mode_next;
        now_reg  <= now_next;
    end

    abrl_ram #(
        .WIDTH (STAMP_W),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .clk     (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (head_reg),
        .wr_data (in_now),
        .rd_en   (ram_rd_en),
        .rd_addr (issue_reg[AW-1:0]),
        .rd_data (ram_rd_data)
    );

    abrl_recent_unit #(
        .CNT_W (CW)
    ) u_recent (
        .clk   (aclk),
        .ctl   (scan_ctl),
        .now   (now_reg),
        .stamp (ram_rd_data),
        .count (hit_count)
    );

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = {{(M_DATA_W - MODE_W){1'b0}}, mode_reg};
endmodule
`default_nettype wire

### hw/rtl/abrl_checker.sv
// Port-level checker for the alert budget rate limiter, bound to the top level.
`default_nettype none
module abrl_checker
    import abrl_pkg::*;
(
    input wire logic                 aclk,
    input wire logic                 aresetn,
    input wire logic                 s_tvalid,
    input wire logic                 s_tready,
    input wire logic [S_DATA_W-1:0]  s_tdata,
    input wire logic [OP_W-1:0]      s_tuser,
    input wire logic                 m_tvalid,
    input wire logic                 m_tready,
    input wire logic [M_DATA_W-1:0]  m_tdata
);
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result item changed while stalled");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && !(s_tvalid && !s_tready && 1'b0))
        else $error("result valid after reset");

    a_ambient_pass: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser == OP_DECIDE
            && s_tdata[STAMP_W+LEVEL_W-1:STAMP_W] == LVL_AMBIENT
        |=> m_tvalid && m_tdata[MODE_W-1:0] == MODE_AMBIENT)
        else $error("ambient request not passed through");

    a_digest_pass: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser == OP_DECIDE
            && s_tdata[STAMP_W+LEVEL_W-1] == 1'b1
        |=> m_tvalid && m_tdata[MODE_W-1:0] == MODE_DIGEST)
        else $error("digest request not mapped to digest");

    a_no_input_while_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input taken while result stalled");
endmodule

bind alert_budget_rate_limiter abrl_checker u_abrl_checker (.*);
`default_nettype wire

### sim/tb_alert_budget_rate_limiter.sv
// Testbench for alert_budget_rate_limiter: directed table plus random item streams, checked by a built-in predictor.
`timescale 1ns / 100ps
module tb_alert_budget_rate_limiter
    import abrl_pkg::*;
;
    localparam int     CLK_NS       = 10;
    localparam longint LIMIT_CYCLES = 1_500_000;
    localparam int     RING_N       = DEF_RING_DEPTH;
    localparam int     DIR_N        = 22;
    localparam int     N_PHASES     = 12;
    localparam int     PHASE_ITEMS  = 160;

    localparam logic [OP_W-1:0]    OP_UNUSED  = 2'd3;
    localparam logic [LEVEL_W-1:0] LVL_DIGEST = 2'd2;
    localparam logic [LEVEL_W-1:0] LVL_OTHER  = 2'd3;

    localparam logic [STAMP_W-1:0] TS_MAX  = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [STAMP_W-1:0] TS_MIN  = 64'h8000_0000_0000_0000;
    localparam logic [STAMP_W-1:0] TS_ONES = '1;
    localparam logic signed [STAMP_W:0] HOUR_SPAN = (STAMP_W + 1)'(HOUR_MS);

    typedef struct {
        logic [OP_W-1:0]    op;
        logic [STAMP_W-1:0] now;
        logic [LEVEL_W-1:0] lvl;
        bit                 typed;
        logic [MODE_W-1:0]  mode;
    } stim_row_t;

    typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_BEAT} rx_style_t;

    logic                  aclk        = 1'b0;
    logic                  aresetn     = 1'b0;
    logic                  cfg_wr_en   = 1'b0;
    logic [BUDGET_W-1:0]   cfg_wr_data = '0;
    logic                  s_tvalid    = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata     = '0;
    logic [OP_W-1:0]       s_tuser     = '0;
    logic                  m_tvalid;
    logic                  m_tready    = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;

    // predictor state
    logic [STAMP_W-1:0]              hist_ts [RING_N];
    logic [$clog2(RING_N)-1:0]       hist_head = '0;
    int                              hist_fill = 0;
    logic [BUDGET_W-1:0]             budget    = BUDGET_RESET;
    logic [MODE_W-1:0]               mode_queue [$];

    int unsigned n_items, n_checked, n_demoted, n_notes, n_full_notes, n_clears, n_cfg;
    int unsigned n_errors;
    int          burst_left = 0;
    bit          steady     = 1'b0;
    logic [31:0] rx_cyc     = '0;
    rx_style_t   rx_style   = RX_OPEN;
    logic [MODE_W-1:0] want_mode;

    alert_budget_rate_limiter uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    always #(CLK_NS / 2) aclk = ~aclk;

    task automatic report_mismatch(input string msg);
        $display("%0t ns MISMATCH: %s", $time, msg);
        n_errors++;
    endtask

    // stamps whose exact distance behind now is under one hour (future stamps count)
    function automatic int recent_stamps(input logic [STAMP_W-1:0] now);
        logic signed [STAMP_W:0] span;
        int n;
        n = 0;
        for (int i = 0; i < hist_fill; i++) begin
            span = $signed({now[STAMP_W-1], now}) - $signed({hist_ts[i][STAMP_W-1], hist_ts[i]});
            if (span < HOUR_SPAN) n++;
        end
        return n;
    endfunction

    task automatic limiter_step(input logic [OP_W-1:0] op, input logic [STAMP_W-1:0] now,
                                input logic [LEVEL_W-1:0] lvl, output bit gives_mode,
                                output logic [MODE_W-1:0] mode);
        gives_mode = 1'b0;
        mode = MODE_ALERT;
        case (op)
            OP_NOTE: begin
                if (hist_fill == RING_N) n_full_notes++;
                hist_ts[hist_head] = now;
                hist_head = hist_head + 1'b1;
                if (hist_fill < RING_N) hist_fill++;
                n_notes++;
            end
            OP_CLEAR: begin
                hist_head = '0;
                hist_fill = 0;
                n_clears++;
            end
            OP_DECIDE: begin
                gives_mode = 1'b1;
                if (lvl == LVL_ALERT) begin
                    if (budget != 0 && recent_stamps(now) >= int'(budget)) begin
                        mode = MODE_AMBIENT;
                        n_demoted++;
                    end else begin
                        mode = MODE_ALERT;
                    end
                end else if (lvl == LVL_AMBIENT) begin
                    mode = MODE_AMBIENT;
                end else begin
                    mode = MODE_DIGEST;
                end
            end
            default: ;
        endcase
    endtask

    task automatic push_item(input logic [OP_W-1:0] op, input logic [STAMP_W-1:0] now,
                             input logic [LEVEL_W-1:0] lvl, input bit typed,
                             input logic [MODE_W-1:0] typed_mode);
        bit gives_mode;
        logic [MODE_W-1:0] mode;
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_DATA_W - STAMP_W - LEVEL_W){1'b0}}, lvl, now};
        s_tuser  <= op;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        limiter_step(op, now, lvl, gives_mode, mode);
        if (gives_mode) mode_queue.push_back(typed ? typed_mode : mode);
        n_items++;
    endtask

    // sender works in bursts separated by random gaps, with no gaps in steady phases
    task automatic paced_item(input logic [OP_W-1:0] op, input logic [STAMP_W-1:0] now,
                              input logic [LEVEL_W-1:0] lvl, input bit typed,
                              input logic [MODE_W-1:0] typed_mode);
        int gap;
        if (burst_left == 0) begin
            gap = steady ? 0 : $urandom_range(0, 8);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        push_item(op, now, lvl, typed, typed_mode);
    endtask

    task automatic drain(input int settle);
        s_tvalid <= 1'b0;
        while (mode_queue.size() != 0) @(posedge aclk);
        repeat (settle) @(posedge aclk);
    endtask

    task automatic set_budget(input logic [BUDGET_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        budget = value;
        cfg_wr_en <= 1'b0;
        n_cfg++;
    endtask

    always @(posedge aclk) begin
        rx_cyc <= rx_cyc + 1;
        if (rx_cyc[8:0] == 0) rx_style <= rx_style_t'($urandom_range(0, 3));
        case (rx_style)
            RX_OPEN:   m_tready <= 1'b1;
            RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
            RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
            default:   m_tready <= rx_cyc[2];
        endcase
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (mode_queue.size() == 0) begin
                report_mismatch($sformatf("unexpected delivery_mode %0d", m_tdata[MODE_W-1:0]));
            end else begin
                want_mode = mode_queue.pop_front();
                n_checked++;
                if (m_tdata[MODE_W-1:0] !== want_mode)
                    report_mismatch($sformatf("delivery_mode %0d, expected %0d",
                                              m_tdata[MODE_W-1:0], want_mode));
            end
        end
    end

    initial begin
        stim_row_t dir_tab [DIR_N];
        logic [STAMP_W-1:0]  t, now;
        logic [OP_W-1:0]     op;
        logic [LEVEL_W-1:0]  lvl;
        logic [BUDGET_W-1:0] bud;
        int r, step, note_pct, clr_pct;

        // budget is 2 while the table runs
        dir_tab = '{
            '{OP_DECIDE, 64'd0,       LVL_ALERT,   1'b1, MODE_ALERT},
            '{OP_DECIDE, TS_MIN,      LVL_AMBIENT, 1'b1, MODE_AMBIENT},
            '{OP_DECIDE, TS_MAX,      LVL_DIGEST,  1'b1, MODE_DIGEST},
            '{OP_DECIDE, TS_ONES,     LVL_OTHER,   1'b1, MODE_DIGEST},
            '{OP_UNUSED, TS_ONES,     LVL_ALERT,   1'b0, MODE_ALERT},
            '{OP_NOTE,   TS_MAX,      LVL_ALERT,   1'b0, MODE_ALERT},
            '{OP_NOTE,   TS_MIN,      LVL_ALERT,   1'b0, MODE_ALERT},
            '{OP_DECIDE, TS_MIN,      LVL_ALERT,   1'b1, MODE_AMBIENT},
            '{OP_DECIDE, TS_MAX,      LVL_ALERT,   1'b1, MODE_ALERT},
            '{OP_CLEAR,  64'd0,       LVL_ALERT,   1'b0, MODE_ALERT},
            '{OP_DECIDE, TS_MAX,      LVL_ALERT,   1'b1, MODE_ALERT},
            '{OP_NOTE,   64'd0,       LVL_ALERT,   1'b0, MODE_ALERT},
            '{OP_NOTE,   64'd1,       LVL_ALERT,   1'b0, MODE_ALERT},
            '{OP_DECIDE, 64'd3600000, LVL_ALERT,   1'b1, MODE_ALERT},
            '{OP_DECIDE, 64'd3599999, LVL_ALERT,   1'b1, MODE_AMBIENT},
            '{OP_NOTE,   TS_ONES,     LVL_ALERT,   1'b0, MODE_ALERT},
            '{OP_DECIDE, 64'd0,       LVL_ALERT,   1'b1, MODE_AMBIENT},
            '{OP_UNUSED, 64'd0,       LVL_OTHER,   1'b0, MODE_ALERT},
            '{OP_DECIDE, 64'd3600001, LVL_ALERT,   1'b0, MODE_ALERT},
            '{OP_NOTE,   64'd3600001, LVL_ALERT,   1'b0, MODE_ALERT},
            '{OP_DECIDE, 64'd7200000, LVL_ALERT,   1'b0, MODE_ALERT},
            '{OP_DECIDE, 64'd3600001, LVL_OTHER,   1'b0, MODE_ALERT}
        };

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        set_budget(7'd2);
        foreach (dir_tab[i])
            paced_item(dir_tab[i].op, dir_tab[i].now, dir_tab[i].lvl,
                       dir_tab[i].typed, dir_tab[i].mode);
        drain(8);

        for (int ph = 0; ph < N_PHASES; ph++) begin
            case (ph)
                0:       bud = 7'd0;
                1:       bud = 7'd127;
                2:       bud = 7'd100;
                3:       bud = 7'd1;
                default: bud = ($urandom_range(0, 1) != 0) ? 7'($urandom_range(1, 12))
                                                           : 7'($urandom_range(0, 127));
            endcase
            set_budget(bud);

            // dense phases fill and wrap the ring within one hour
            if (ph == 1 || ph == 2) begin
                step     = 1000;
                note_pct = 70;
            end else begin
                case ($urandom_range(0, 3))
                    0:       step = 1000;
                    1:       step = 20000;
                    2:       step = 400000;
                    default: step = 4000000;
                endcase
                note_pct = $urandom_range(25, 60);
            end
            clr_pct = (ph < 3) ? 0 : $urandom_range(0, 3);

            case ($urandom_range(0, 3))
                0:       t = TS_MAX - 64'($urandom_range(0, 5000000));
                1:       t = TS_MIN + 64'($urandom_range(0, 5000000));
                default: t = {$urandom, $urandom};
            endcase
            steady     = ($urandom_range(0, 3) == 0);
            burst_left = 0;

            for (int k = 0; k < PHASE_ITEMS; k++) begin
                r   = $urandom_range(0, 99);
                lvl = ($urandom_range(0, 9) < 7) ? LVL_ALERT : 2'($urandom_range(0, 3));
                if (r < 4) begin
                    op  = 2'($urandom_range(0, 3));
                    now = {$urandom, $urandom};
                    lvl = 2'($urandom_range(0, 3));
                end else if (r < 4 + clr_pct) begin
                    op  = OP_CLEAR;
                    now = t;
                end else if (r < 6 + clr_pct) begin
                    op  = OP_UNUSED;
                    now = t;
                end else if (r < 6 + clr_pct + note_pct) begin
                    op  = OP_NOTE;
                    t   = t + 64'($urandom_range(0, step));
                    now = t;
                end else begin
                    op = OP_DECIDE;
                    case ($urandom_range(0, 3))
                        0: begin
                            // probe the one-hour edge of a stored stamp
                            if (hist_fill != 0)
                                now = hist_ts[$urandom_range(0, hist_fill - 1)]
                                      + 64'(HOUR_MS) - 64'd2 + 64'($urandom_range(0, 4));
                            else
                                now = t;
                        end
                        1:       now = t - 64'($urandom_range(0, step));
                        default: now = t + 64'($urandom_range(0, step));
                    endcase
                end
                paced_item(op, now, lvl, 1'b0, MODE_ALERT);
            end
            drain(8);
        end

        drain(140);

        $display("covered %0d items over %0d budget settings: %0d modes checked, %0d alerts demoted",
                 n_items, n_cfg, n_checked, n_demoted);
        $display("history: %0d notes (%0d onto a full ring), %0d clears, %0d mismatches",
                 n_notes, n_full_notes, n_clears, n_errors);
        if (n_errors == 0)
            $display("tb_alert_budget_rate_limiter passed");
        else
            $display("tb_alert_budget_rate_limiter failed");
        $finish;
    end

    initial begin
        #(CLK_NS * LIMIT_CYCLES);
        $display("timeout: %0d modes still expected", mode_queue.size());
        $display("tb_alert_budget_rate_limiter failed");
        $finish;
    end
endmodule

### alert_budget_rate_limiter.f
hw/rtl/abrl_pkg.sv
hw/rtl/abrl_ram.sv
hw/rtl/abrl_recent_unit.sv
hw/rtl/alert_budget_rate_limiter.sv
hw/rtl/abrl_checker.sv
sim/tb_alert_budget_rate_limiter.sv
